@@ src/hcb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder package
// Request and response types and operation codes.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam logic [1:0] OP_COUNT  = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_ENCODE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] symbol;
    } t_req;

    typedef struct packed {
        logic [31:0] code_bits;
        logic [5:0]  code_length;
        logic        symbol_present;
        logic [8:0]  leaf_count;
        logic        overflow;
    } t_rsp;

endpackage
`default_nettype wire

@@ src/huffman_code_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder
// Symbol histogram, static Huffman tree construction and code lookup.
//
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_in_data  (t_req)
// response  out        o_out_valid / i_out_ready o_out_data (t_rsp)
//
// Count and clear return to idle without a response; encode waits until the
// output register is free.
// Build: a scan of the alphabet for leaves, then per merge a scan of all nodes
// so far over the one weight read port, then per leaf a walk up to the root.
// One request at a time; a response waits in the output register for ready.
// Reset (synchronous, active low) clears counts, code valid bits and flags.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
    parameter int ALPHABET_SIZE = 256,
    parameter int COUNT_WIDTH   = 16,
    parameter int MAX_CODE_BITS = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  hcb_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output hcb_pkg::t_rsp  o_out_data
);

    localparam int A  = ALPHABET_SIZE;
    localparam int SW = $clog2(A);
    localparam int NN = 2 * A - 1;
    localparam int NW = $clog2(NN);
    localparam int CW = COUNT_WIDTH;
    localparam int WW = CW + 1;
    localparam logic [5:0] CL = 6'((MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CT_WR  = 5'd1;
    localparam logic [4:0] S_EN_EX  = 5'd2;
    localparam logic [4:0] S_LF_RD  = 5'd3;
    localparam logic [4:0] S_LF_EX  = 5'd4;
    localparam logic [4:0] S_ONE_RD = 5'd5;
    localparam logic [4:0] S_ONE_WR = 5'd6;
    localparam logic [4:0] S_MG_ST  = 5'd7;
    localparam logic [4:0] S_MG_RD  = 5'd8;
    localparam logic [4:0] S_MG_EX  = 5'd9;
    localparam logic [4:0] S_MG_W1  = 5'd10;
    localparam logic [4:0] S_MG_W2  = 5'd11;
    localparam logic [4:0] S_MG_W3  = 5'd12;
    localparam logic [4:0] S_WK_ST  = 5'd13;
    localparam logic [4:0] S_WK_CHK = 5'd14;
    localparam logic [4:0] S_WK_EX  = 5'd15;
    localparam logic [4:0] S_WK_SYM = 5'd16;
    localparam logic [4:0] S_WK_WR  = 5'd17;
    localparam logic [4:0] S_EMIT   = 5'd18;

    logic [CW-1:0]  cnt_mem  [A];
    logic [WW-1:0]  nw_mem   [NN];
    logic [NW:0]    np_mem   [NN];
    logic [SW-1:0]  nsym_mem [A];
    logic [37:0]    code_mem [A];

    logic [4:0]     r_state;
    logic [A-1:0]   r_cnt_vld;
    logic [A-1:0]   r_code_vld;
    logic [CW-1:0]  r_total;
    logic           r_ovf;
    logic [SW-1:0]  r_sym;
    logic           r_hit;
    logic [SW-1:0]  r_s;
    logic [NW-1:0]  r_leaves;
    logic [NW-1:0]  r_i;
    logic [NW-1:0]  r_j;
    logic [NW-1:0]  r_best;
    logic [NW-1:0]  r_sec;
    logic [WW-1:0]  r_best_w;
    logic [WW-1:0]  r_sec_w;
    logic [NW-1:0]  r_k;
    logic [NW-1:0]  r_cur;
    logic [5:0]     r_depth;
    logic [31:0]    r_bits;
    hcb_pkg::t_rsp  r_res;
    logic           r_out_valid;
    hcb_pkg::t_rsp  r_out;

    logic [CW-1:0]  r_cnt_q;
    logic [WW-1:0]  r_nw_q;
    logic [NW:0]    r_np_q;
    logic [SW-1:0]  r_nsym_q;
    logic [37:0]    r_code_q;

    logic           in_acc;
    logic [SW-1:0]  in_idx;
    logic           in_range;
    logic [SW-1:0]  cnt_addr;
    logic [SW-1:0]  nsym_addr;
    logic [CW-1:0]  cnt_cur;
    logic [NW-1:0]  n_leaves;
    logic [NW-1:0]  root;
    logic           nw_we;
    logic [NW-1:0]  nw_wa;
    logic [WW-1:0]  nw_wd;
    logic           np_we;
    logic [NW-1:0]  np_wa;
    logic [NW:0]    np_wd;
    logic           out_free;
    hcb_pkg::t_rsp  build_res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign in_idx      = i_in_data.symbol[SW-1:0];
    assign in_range    = (9'(i_in_data.symbol) < 9'(A));
    assign cnt_addr    = (r_state == S_IDLE) ? in_idx : r_s;
    assign nsym_addr   = (r_state == S_WK_SYM) ? r_k[SW-1:0] : '0;
    assign cnt_cur     = (r_state == S_CT_WR) ? (r_cnt_vld[r_sym] ? r_cnt_q : '0)
                                              : (r_cnt_vld[r_s] ? r_cnt_q : '0);
    assign n_leaves    = (cnt_cur != '0) ? r_leaves + 1'b1 : r_leaves;
    assign root        = NW'({r_leaves, 1'b0} - 2);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        build_res                = '0;
        build_res.leaf_count     = 9'(r_leaves);
        build_res.overflow       = r_ovf;
        nw_we = 1'b0;
        nw_wa = r_i;
        nw_wd = '1;
        np_we = 1'b0;
        np_wa = r_best;
        np_wd = {1'b0, r_i};
        unique case (r_state)
            S_LF_EX: begin
                nw_we = (cnt_cur != '0);
                nw_wa = r_leaves;
                nw_wd = {1'b0, cnt_cur};
            end
            S_MG_W1: begin
                nw_we = 1'b1;
                nw_wa = r_best;
                np_we = 1'b1;
            end
            S_MG_W2: begin
                nw_we = 1'b1;
                nw_wa = r_sec;
                np_we = 1'b1;
                np_wa = r_sec;
                np_wd = {1'b1, r_i};
            end
            S_MG_W3: begin
                nw_we = 1'b1;
                nw_wd = r_best_w + r_sec_w;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt_q <= cnt_mem[cnt_addr];
        if (r_state == S_CT_WR) begin
            cnt_mem[r_sym] <= cnt_cur + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nw_q <= nw_mem[r_j];
        if (nw_we) begin
            nw_mem[nw_wa] <= nw_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_np_q <= np_mem[r_cur];
        if (np_we) begin
            np_mem[np_wa] <= np_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nsym_q <= nsym_mem[nsym_addr];
        if (r_state == S_LF_EX && cnt_cur != '0) begin
            nsym_mem[r_leaves[SW-1:0]] <= r_s;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code_q <= code_mem[in_idx];
        if (r_state == S_ONE_WR) begin
            code_mem[r_nsym_q] <= {6'd1, 32'd0};
        end else if (r_state == S_WK_WR) begin
            code_mem[r_nsym_q] <= {r_depth, r_bits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_vld   <= '0;
            r_code_vld  <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_leaves    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in_data.operation)
                            hcb_pkg::OP_COUNT: begin
                                if (r_total == '1) begin
                                    r_ovf <= 1'b1;
                                end else if (in_range) begin
                                    r_total <= r_total + 1'b1;
                                    r_sym   <= in_idx;
                                    r_state <= S_CT_WR;
                                end
                            end
                            hcb_pkg::OP_BUILD: begin
                                r_code_vld <= '0;
                                r_leaves   <= '0;
                                r_s        <= '0;
                                r_state    <= S_LF_RD;
                            end
                            hcb_pkg::OP_ENCODE: begin
                                r_hit   <= in_range && r_code_vld[in_idx];
                                r_state <= S_EN_EX;
                            end
                            hcb_pkg::OP_CLEAR: begin
                                r_cnt_vld  <= '0;
                                r_code_vld <= '0;
                                r_total    <= '0;
                                r_ovf      <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CT_WR: begin
                    r_cnt_vld[r_sym] <= 1'b1;
                    r_state          <= S_IDLE;
                end
                S_EN_EX: begin
                    r_res          <= '0;
                    r_res.overflow <= r_ovf;
                    if (r_hit) begin
                        r_res.code_bits      <= r_code_q[31:0];
                        r_res.code_length    <= r_code_q[37:32];
                        r_res.symbol_present <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_LF_RD: begin
                    r_state <= S_LF_EX;
                end
                S_LF_EX: begin
                    r_leaves <= n_leaves;
                    if (r_s == SW'(A - 1)) begin
                        if (n_leaves == '0) begin
                            r_res   <= build_res;
                            r_state <= S_EMIT;
                        end else if (n_leaves == NW'(1)) begin
                            r_state <= S_ONE_RD;
                        end else begin
                            r_i     <= n_leaves;
                            r_state <= S_MG_ST;
                        end
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_LF_RD;
                    end
                end
                S_ONE_RD: begin
                    r_state <= S_ONE_WR;
                end
                S_ONE_WR: begin
                    r_code_vld[r_nsym_q] <= 1'b1;
                    r_res                <= build_res;
                    r_state              <= S_EMIT;
                end
                S_MG_ST: begin
                    r_j      <= '0;
                    r_best_w <= '1;
                    r_sec_w  <= '1;
                    r_state  <= S_MG_RD;
                end
                S_MG_RD: begin
                    r_state <= S_MG_EX;
                end
                S_MG_EX: begin
                    if (r_nw_q < r_best_w) begin
                        r_sec    <= r_best;
                        r_sec_w  <= r_best_w;
                        r_best   <= r_j;
                        r_best_w <= r_nw_q;
                    end else if (r_nw_q < r_sec_w) begin
                        r_sec   <= r_j;
                        r_sec_w <= r_nw_q;
                    end
                    if (r_j == r_i - 1'b1) begin
                        r_state <= S_MG_W1;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_MG_RD;
                    end
                end
                S_MG_W1: begin
                    r_state <= S_MG_W2;
                end
                S_MG_W2: begin
                    r_state <= S_MG_W3;
                end
                S_MG_W3: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == root) begin
                        r_k     <= '0;
                        r_state <= S_WK_ST;
                    end else begin
                        r_state <= S_MG_ST;
                    end
                end
                S_WK_ST: begin
                    r_cur   <= r_k;
                    r_depth <= '0;
                    r_bits  <= '0;
                    r_state <= S_WK_CHK;
                end
                S_WK_CHK: begin
                    if (r_cur == root) begin
                        r_state <= S_WK_SYM;
                    end else if (r_depth >= CL) begin
                        if (r_k == r_leaves - 1'b1) begin
                            r_res   <= build_res;
                            r_state <= S_EMIT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_WK_ST;
                        end
                    end else begin
                        r_state <= S_WK_EX;
                    end
                end
                S_WK_EX: begin
                    r_bits[r_depth[4:0]] <= r_np_q[NW];
                    r_depth              <= r_depth + 1'b1;
                    r_cur                <= r_np_q[NW-1:0];
                    r_state              <= S_WK_CHK;
                end
                S_WK_SYM: begin
                    r_state <= S_WK_WR;
                end
                S_WK_WR: begin
                    r_code_vld[r_nsym_q] <= 1'b1;
                    if (r_k == r_leaves - 1'b1) begin
                        r_res   <= build_res;
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_WK_ST;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_leaves_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_leaves <= NW'(A)))
        else $error("leaf count beyond alphabet");

    a_code_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.symbol_present) |->
        (o_out_data.code_length != 6'd0 && o_out_data.code_length <= CL))
        else $error("present symbol with bad code length");

    a_build_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.leaf_count != 9'd0) |->
        (!o_out_data.symbol_present && o_out_data.code_length == 6'd0))
        else $error("build response carries a code");
`endif

endmodule
`default_nettype wire
